// ===== rtl/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types, constants and the seven-segment encoder of the button counter.
// ----------------------------------------------------------------------------
package dbc_pkg;

  localparam int NumButtonsMax    = 8;
  localparam int NumButtonsDef    = 8;
  localparam int StableSamplesDef = 12;
  localparam int CountW           = 16;
  localparam int SegW             = 8;

  typedef logic [NumButtonsMax-1:0] levels_t;
  typedef logic [CountW-1:0]        count_t;
  typedef logic [SegW-1:0]          seg_t;
  typedef logic [6:0]               digit_t;

  // count / 1000 == (count * ThouRecip) >> ThouShift for every 16-bit count
  localparam logic [16:0] ThouRecip = 17'd67109;
  localparam int          ThouShift = 26;

  localparam seg_t SegDash    = 8'hBF;
  localparam seg_t ColonOdd   = 8'hFC;
  localparam seg_t ColonEven  = 8'hFF;

  function automatic seg_t seg_encode(input digit_t d);
    seg_t s;
    case (d)
      7'd0:    s = 8'hC0;
      7'd1:    s = 8'hF9;
      7'd2:    s = 8'hA4;
      7'd3:    s = 8'hB0;
      7'd4:    s = 8'h99;
      7'd5:    s = 8'h92;
      7'd6:    s = 8'h82;
      7'd7:    s = 8'hF8;
      7'd8:    s = 8'h80;
      7'd9:    s = 8'h98;
      default: s = SegDash;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/dbc_if.sv =====
// ----------------------------------------------------------------------------
// dbc_if
// Valid/ready channels for button samples and for display results.
// ----------------------------------------------------------------------------
interface dbc_in_if;
  import dbc_pkg::*;

  logic    valid;
  logic    ready;
  levels_t raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface dbc_out_if;
  import dbc_pkg::*;

  logic    valid;
  logic    ready;
  count_t  count_value;
  levels_t press_mask;
  seg_t    seg_ones;
  seg_t    seg_tens;
  seg_t    seg_colon;
  seg_t    seg_hundreds;
  seg_t    seg_thousands;

  modport source (
    output valid, output count_value, output press_mask, output seg_ones,
    output seg_tens, output seg_colon, output seg_hundreds, output seg_thousands,
    input ready
  );
  modport sink (
    input valid, input count_value, input press_mask, input seg_ones,
    input seg_tens, input seg_colon, input seg_hundreds, input seg_thousands,
    output ready
  );
endinterface

// ===== rtl/dbc_lane.sv =====
// ----------------------------------------------------------------------------
// dbc_lane
// One button: sample shift history and single-shot press detection.
// ----------------------------------------------------------------------------
module dbc_lane #(
  parameter int STABLE_SAMPLES = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic level_i,
  output logic press_o
);

  localparam int HistW = STABLE_SAMPLES + 1;
  localparam logic [HistW-1:0] PressPat = {1'b1, {STABLE_SAMPLES{1'b0}}};

  logic [HistW-1:0] hist_q, hist_d;

  assign hist_d  = {hist_q[HistW-2:0], level_i};
  assign press_o = (hist_d == PressPat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (en_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

// ===== rtl/dbc_merge.sv =====
// ----------------------------------------------------------------------------
// dbc_merge
// Merge lane presses into the running count (each press adds its weight).
// ----------------------------------------------------------------------------
module dbc_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dbc_pkg::levels_t press_mask_i,
  output dbc_pkg::count_t  count_o
);
  import dbc_pkg::*;

  count_t count_q, count_d;

  assign count_d = count_q + CountW'(press_mask_i);
  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/dbc_decode.sv =====
// ----------------------------------------------------------------------------
// dbc_decode
// Pipelined decimal split of the count and seven-segment encoding.
// ----------------------------------------------------------------------------
module dbc_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  dbc_pkg::count_t   count_i,
  input  dbc_pkg::levels_t  mask_i,
  dbc_out_if.source         out_o
);
  import dbc_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  count_t  cnt1_q, cnt2_q, cnt3_q, cnt4_q, cnt5_q;
  levels_t msk1_q, msk2_q, msk3_q, msk4_q, msk5_q;
  digit_t  th2_q, th3_q, th4_q;
  logic [9:0] rem3_q;
  logic [3:0] hu4_q;
  logic [6:0] r4_q;
  seg_t    seg_on_q, seg_te_q, seg_co_q, seg_hu_q, seg_th_q;

  logic [32:0] prod;
  digit_t      th_d;
  count_t      rem_full;
  logic [3:0]  hu_d, te_d, on_d;
  logic [9:0]  hu_x100;
  logic [9:0]  r_full;
  logic [6:0]  te_x10;

  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= req_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign prod     = 33'(cnt1_q) * 33'(ThouRecip);
  assign th_d     = prod[ThouShift +: 7];
  assign rem_full = cnt2_q - CountW'(th2_q) * CountW'(1000);

  always_comb begin
    hu_d = '0;
    for (int j = 1; j <= 9; j++) begin
      hu_d = hu_d + 4'(rem3_q >= 10'(j * 100));
    end
    hu_x100 = 10'(hu_d) * 10'd100;
    r_full  = rem3_q - hu_x100;
  end

  always_comb begin
    te_d = '0;
    for (int j = 1; j <= 9; j++) begin
      te_d = te_d + 4'(r4_q >= 7'(j * 10));
    end
    te_x10 = 7'(te_d) * 7'd10;
    on_d   = 4'(r4_q - te_x10);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cnt1_q <= count_i;
      msk1_q <= mask_i;
    end
    if (en2) begin
      cnt2_q <= cnt1_q;
      msk2_q <= msk1_q;
      th2_q  <= th_d;
    end
    if (en3) begin
      cnt3_q <= cnt2_q;
      msk3_q <= msk2_q;
      th3_q  <= th2_q;
      rem3_q <= rem_full[9:0];
    end
    if (en4) begin
      cnt4_q <= cnt3_q;
      msk4_q <= msk3_q;
      th4_q  <= th3_q;
      hu4_q  <= hu_d;
      r4_q   <= r_full[6:0];
    end
    if (en5) begin
      cnt5_q   <= cnt4_q;
      msk5_q   <= msk4_q;
      seg_th_q <= seg_encode(th4_q);
      seg_hu_q <= seg_encode(7'(hu4_q));
      seg_te_q <= seg_encode(7'(te_d));
      seg_on_q <= seg_encode(7'(on_d));
      seg_co_q <= on_d[0] ? ColonOdd : ColonEven;
    end
  end

  assign out_o.valid         = v5_q;
  assign out_o.count_value   = cnt5_q;
  assign out_o.press_mask    = msk5_q;
  assign out_o.seg_ones      = seg_on_q;
  assign out_o.seg_tens      = seg_te_q;
  assign out_o.seg_colon     = seg_co_q;
  assign out_o.seg_hundreds  = seg_hu_q;
  assign out_o.seg_thousands = seg_th_q;

endmodule

// ===== rtl/debounced_button_counter_display_core.sv =====
// ----------------------------------------------------------------------------
// debounced_button_counter_display_core
// Debounced button press counter with seven-segment digit output.
//
//   channel | dir | payload                                       | accept
//   in_i    | in  | raw_levels                                    | valid & ready
//   out_o   | out | count_value, press_mask, seg_* (five bytes)   | valid & ready
//
// One sample request accepted per cycle unless an output stall backs up all
// stages; its result is valid after five register stages (decimal split:
// reciprocal multiply for the thousands, then hundreds, then tens/ones), the
// first loaded at the accepting edge. The count add is registered.
// Reset clears all button histories, the count and every pipeline valid.
// An output stall backs up the stages; empty stages keep accepting.
// ----------------------------------------------------------------------------
module debounced_button_counter_display_core #(
  parameter int NUM_BUTTONS    = dbc_pkg::NumButtonsDef,
  parameter int STABLE_SAMPLES = dbc_pkg::StableSamplesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbc_in_if.sink    in_i,
  dbc_out_if.source out_o
);
  import dbc_pkg::*;

  logic    accept;
  levels_t press;
  count_t  count_new;

  assign accept = in_i.valid && in_i.ready;

  for (genvar k = 0; k < NumButtonsMax; k++) begin : g_lane
    if (k < NUM_BUTTONS) begin : g_used
      dbc_lane #(
        .STABLE_SAMPLES(STABLE_SAMPLES)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .level_i(in_i.raw_levels[k]),
        .press_o(press[k])
      );
    end else begin : g_unused
      assign press[k] = 1'b0;
    end
  end

  dbc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .press_mask_i(press),
    .count_o     (count_new)
  );

  dbc_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_i.valid),
    .req_ready_o(in_i.ready),
    .count_i    (count_new),
    .mask_i     (press),
    .out_o      (out_o)
  );

endmodule
